@@ rtl/cbm_pkg.sv @@
// Package: shared types, request codes and constants for the cartridge bank mapper.
`timescale 1ns / 1ps

package cbm_pkg;

    // Request codes
    localparam logic [2:0] REQ_ROM_LO   = 3'd0;
    localparam logic [2:0] REQ_ROM_HI   = 3'd1;
    localparam logic [2:0] REQ_RAM_RD   = 3'd2;
    localparam logic [2:0] REQ_RAM_WR   = 3'd3;
    localparam logic [2:0] REQ_REG_WR   = 3'd4;

    // Register write regions, taken from addr[15:13]
    localparam logic [2:0] REGION_LOCK_ENABLE = 3'd0;  // 0x0000-0x1FFF
    localparam logic [2:0] REGION_ROM_BANK    = 3'd1;  // 0x2000-0x3FFF
    localparam logic [2:0] REGION_RAM_BANK    = 3'd2;  // 0x4000-0x5FFF

    localparam logic [3:0] RAM_ON_CODE   = 4'hA;
    localparam logic [7:0] RAM_OFF_DATA  = 8'hFF;

    localparam int         ROM_AW        = 23;
    localparam logic [4:0] ROM_LOG2_MIN  = 5'd15;
    localparam logic [4:0] ROM_LOG2_MAX  = 5'd23;
    localparam logic [4:0] ROM_LOG2_RST  = 5'd15;
    localparam int         WINDOW_SHIFT  = 14;
    localparam int         RAM_PAGE_BITS = 13;

    localparam int         RAM_BYTES_DEFAULT = 32768;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] addr;
        logic [7:0]  data;
    } cbm_req_t;

    typedef struct packed {
        logic [22:0] rom_addr;
        logic [7:0]  ram_data;
        logic        ram_enabled;
    } cbm_result_t;

    // Access to cart RAM from the mapping logic
    typedef struct packed {
        logic                     rd;
        logic                     wr;
        logic [7:0]               bank;
        logic [RAM_PAGE_BITS-1:0] offset;
        logic [7:0]               wdata;
    } cbm_ram_cmd_t;

endpackage

@@ rtl/cbm_regs.sv @@
// Mapping registers, register-write decode and ROM address mapping.
`timescale 1ns / 1ps

module cbm_regs
    import cbm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  cbm_req_t     req,
    input  logic         cfg_we,
    input  logic [4:0]   cfg_wdata,
    output logic [22:0]  rom_addr,
    output cbm_ram_cmd_t ram_cmd,
    output logic         ram_on,
    output logic         ram_on_next
);

    logic [4:0]  rom_log2_reg;
    logic        locked_reg,   locked_next;
    logic [3:0]  nibble_reg,   nibble_next;
    logic [5:0]  base_reg,     base_next;
    logic [7:0]  select_reg,   select_next;
    logic [7:0]  bank_reg,     bank_next;

    logic [4:0]  log2_clamped;
    logic [23:0] size_bytes;
    logic [22:0] rom_mask;
    logic [22:0] last32k;
    logic [8:0]  hi_bank;
    logic [22:0] rom_raw;

    // Clamp the ROM size and derive mask and last-32K offset
    always_comb
    begin
        if (rom_log2_reg < ROM_LOG2_MIN)
        begin
            log2_clamped = ROM_LOG2_MIN;
        end
        else if (rom_log2_reg > ROM_LOG2_MAX)
        begin
            log2_clamped = ROM_LOG2_MAX;
        end
        else
        begin
            log2_clamped = rom_log2_reg;
        end
        size_bytes = 24'd1 << log2_clamped;
        rom_mask   = 23'(size_bytes - 24'd1);
        last32k    = 23'(size_bytes - 24'h8000);
    end

    // Map the ROM windows
    always_comb
    begin
        hi_bank = {3'd0, base_reg} + {1'b0, select_reg};
        rom_raw = '0;
        case (req.req_type)
            REQ_ROM_LO:
            begin
                if (locked_reg)
                begin
                    rom_raw = {7'd0, req.addr} + {3'd0, base_reg, 14'd0};
                end
                else
                begin
                    rom_raw = {7'd0, req.addr} + last32k;
                end
            end
            REQ_ROM_HI:
            begin
                if (locked_reg)
                begin
                    rom_raw = {9'd0, req.addr[WINDOW_SHIFT-1:0]} + {hi_bank, 14'd0};
                end
                else
                begin
                    rom_raw = {7'd0, req.addr} + last32k;
                end
            end
            default:
            begin
                rom_raw = '0;
            end
        endcase
        rom_addr = rom_raw & rom_mask;
    end

    // Decode register writes
    always_comb
    begin
        locked_next = locked_reg;
        nibble_next = nibble_reg;
        base_next   = base_reg;
        select_next = select_reg;
        bank_next   = bank_reg;
        if (accept && req.req_type == REQ_REG_WR)
        begin
            unique case (req.addr[15:13])
                REGION_LOCK_ENABLE:
                begin
                    if (!locked_reg)
                    begin
                        locked_next = 1'b1;
                    end
                    else
                    begin
                        nibble_next = req.data[3:0];
                    end
                end
                REGION_ROM_BANK:
                begin
                    if (!locked_reg)
                    begin
                        base_next = req.data[5:0];
                    end
                    else
                    begin
                        select_next = req.data;
                    end
                end
                REGION_RAM_BANK:
                begin
                    if (locked_reg)
                    begin
                        bank_next = req.data;
                    end
                end
                default:
                begin
                    // upper regions ignore writes
                end
            endcase
        end
    end

    assign ram_on      = (nibble_reg == RAM_ON_CODE);
    assign ram_on_next = (nibble_next == RAM_ON_CODE);

    // Issue RAM accesses only while the RAM is enabled
    always_comb
    begin
        ram_cmd.rd     = accept && (req.req_type == REQ_RAM_RD) && ram_on;
        ram_cmd.wr     = accept && (req.req_type == REQ_RAM_WR) && ram_on;
        ram_cmd.bank   = bank_reg;
        ram_cmd.offset = req.addr[RAM_PAGE_BITS-1:0];
        ram_cmd.wdata  = req.data;
    end

    // Hold mapping state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_log2_reg <= ROM_LOG2_RST;
            locked_reg   <= 1'b0;
            nibble_reg   <= '0;
            base_reg     <= '0;
            select_reg   <= '0;
            bank_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                rom_log2_reg <= cfg_wdata;
            end
            locked_reg <= locked_next;
            nibble_reg <= nibble_next;
            base_reg   <= base_next;
            select_reg <= select_next;
            bank_reg   <= bank_next;
        end
    end

endmodule

@@ rtl/cbm_ram.sv @@
// Cart RAM: single-port byte memory with registered read data.
`timescale 1ns / 1ps

module cbm_ram
    import cbm_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEFAULT
)
(
    input  logic         clk,
    input  cbm_ram_cmd_t cmd,
    output logic [7:0]   rdata
);

    localparam int AW = $clog2(RAM_BYTES);

    logic [7:0]    mem [RAM_BYTES];
    logic [20:0]   full_index;
    logic [AW-1:0] index;

    // Bank and page offset do not overlap, so the sum is a concatenation
    assign full_index = {cmd.bank, cmd.offset};
    assign index      = full_index[AW-1:0];

    // Write or read one byte
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[index] <= cmd.wdata;
        end
        if (cmd.rd)
        begin
            rdata <= mem[index];
        end
    end

endmodule

@@ rtl/cartridge_bank_mapper_core.sv @@
// Top level: cartridge bank mapper with lock flag, ROM mapping and cart RAM.
`timescale 1ns / 1ps

// Takes one item per clock: busy stays low, and every accepted item gives
// exactly one result, shown on result with done high for one cycle, in the
// cycle after the item was taken. That delay is set by the cart
// RAM's registered read port; ROM addresses are mapped in the accept cycle and
// registered alongside. The receiver has no way to stall and must take each
// result in the cycle it appears. Write the ROM size register through cfg_we
// and cfg_wdata only while no item is in flight.
module cartridge_bank_mapper_core
    import cbm_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cbm_req_t    req,
    output logic        done,
    output cbm_result_t result,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);

    logic         accept;
    logic [22:0]  rom_addr;
    cbm_ram_cmd_t ram_cmd;
    logic         ram_on;
    logic         ram_on_next;
    logic [7:0]   ram_q;

    logic         done_reg;
    logic [22:0]  rom_addr_reg;
    logic         ram_en_reg;
    logic         is_ram_rd_reg;
    logic         rd_on_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cbm_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req         (req),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .rom_addr    (rom_addr),
        .ram_cmd     (ram_cmd),
        .ram_on      (ram_on),
        .ram_on_next (ram_on_next)
    );

    cbm_ram #(
        .RAM_BYTES (RAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .cmd   (ram_cmd),
        .rdata (ram_q)
    );

    // Advance the done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    // Capture the result fields of the accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rom_addr_reg  <= rom_addr;
            ram_en_reg    <= ram_on_next;
            is_ram_rd_reg <= (req.req_type == REQ_RAM_RD);
            rd_on_reg     <= ram_on;
        end
    end

    // Select RAM byte, disabled filler or zero
    always_comb
    begin
        result.rom_addr    = rom_addr_reg;
        result.ram_enabled = ram_en_reg;
        if (!is_ram_rd_reg)
        begin
            result.ram_data = '0;
        end
        else if (rd_on_reg)
        begin
            result.ram_data = ram_q;
        end
        else
        begin
            result.ram_data = RAM_OFF_DATA;
        end
    end

    assign done = done_reg;

endmodule

@@ test/cartridge_bank_mapper_core_test.sv @@
// Testbench: random and directed bus accesses checked against a mapper predictor.
`timescale 1ns / 1ps

module cartridge_bank_mapper_core_test;
    import cbm_pkg::*;

    localparam int          MEM_BYTES     = RAM_BYTES_DEFAULT;
    localparam logic [31:0] PAGE_OFFSET   = 32'h1FFF;
    localparam logic [31:0] WINDOW_OFFSET = 32'h3FFF;
    localparam logic [31:0] LAST_TWO_BANKS = 32'h8000;
    localparam logic [2:0]  REQ_BAD_LO    = 3'd5;
    localparam logic [2:0]  REQ_BAD_HI    = 3'd7;
    localparam int          SETTLE_CYCLES = 3;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          PHASE_ITEMS   = 215;

    // Mirror of the mapper: registers, cart RAM image and pending results
    class map_scoreboard;
        logic [4:0]  rom_log2;
        bit          locked;
        logic [3:0]  enable_nibble;
        logic [5:0]  base_bank;
        logic [7:0]  select_bank;
        logic [7:0]  ram_bank;
        logic [7:0]  ram_img [MEM_BYTES];
        bit          written [MEM_BYTES];
        int          written_idx [$];
        cbm_result_t expected_q [$];
        int          errors;

        function new();
            rom_log2      = ROM_LOG2_RST;
            locked        = 1'b0;
            enable_nibble = '0;
            base_bank     = '0;
            select_bank   = '0;
            ram_bank      = '0;
            errors        = 0;
        endfunction

        function bit ram_on();
            return enable_nibble == RAM_ON_CODE;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Clamp the size register to the legal range before building the mask
        function logic [31:0] rom_mask();
            logic [4:0] lg;
            lg = rom_log2;
            if (lg < ROM_LOG2_MIN) lg = ROM_LOG2_MIN;
            if (lg > ROM_LOG2_MAX) lg = ROM_LOG2_MAX;
            return (32'd1 << lg) - 32'd1;
        endfunction

        function logic [31:0] ram_index(logic [15:0] a);
            return ((32'(ram_bank) << RAM_PAGE_BITS) + (32'(a) & PAGE_OFFSET))
                & (MEM_BYTES - 1);
        endfunction

        // Pick a bus address that hits a written byte in the current RAM page
        function bit find_read_addr(output logic [15:0] a);
            logic [31:0] idx;
            logic [31:0] page;
            a = '0;
            page = (32'(ram_bank) << RAM_PAGE_BITS) & (MEM_BYTES - 1);
            if (written_idx.size() == 0)
                return 1'b0;
            repeat (40)
            begin
                idx = written_idx[$urandom_range(written_idx.size() - 1)];
                if ((idx & ~PAGE_OFFSET) == page)
                begin
                    a = 16'($urandom);
                    a[RAM_PAGE_BITS-1:0] = idx[RAM_PAGE_BITS-1:0];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Advance the mirror by one accepted item and queue its result
        function void note_item(cbm_req_t r);
            logic [31:0] mask;
            logic [31:0] rom;
            logic [31:0] idx;
            cbm_result_t exp_res;
            mask = rom_mask();
            rom = '0;
            exp_res = '0;
            idx = ram_index(r.addr);
            case (r.req_type)
                REQ_ROM_LO:
                begin
                    if (locked)
                        rom = 32'(r.addr) + (32'(base_bank) << WINDOW_SHIFT);
                    else
                        rom = 32'(r.addr) + mask + 32'd1 - LAST_TWO_BANKS;
                    rom = rom & mask;
                end
                REQ_ROM_HI:
                begin
                    if (locked)
                        rom = (32'(r.addr) & WINDOW_OFFSET)
                            + (32'(base_bank) << WINDOW_SHIFT)
                            + (32'(select_bank) << WINDOW_SHIFT);
                    else
                        rom = 32'(r.addr) + mask + 32'd1 - LAST_TWO_BANKS;
                    rom = rom & mask;
                end
                REQ_RAM_RD:
                    exp_res.ram_data = ram_on() ? ram_img[idx] : RAM_OFF_DATA;
                REQ_RAM_WR:
                begin
                    if (ram_on())
                    begin
                        ram_img[idx] = r.data;
                        if (!written[idx])
                        begin
                            written[idx] = 1'b1;
                            written_idx.push_back(idx);
                        end
                    end
                end
                REQ_REG_WR:
                begin
                    case (r.addr[15:13])
                        REGION_LOCK_ENABLE:
                        begin
                            if (!locked)
                                locked = 1'b1;
                            else
                                enable_nibble = r.data[3:0];
                        end
                        REGION_ROM_BANK:
                        begin
                            if (!locked)
                                base_bank = r.data[5:0];
                            else
                                select_bank = r.data;
                        end
                        REGION_RAM_BANK:
                        begin
                            if (locked)
                                ram_bank = r.data;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            exp_res.rom_addr = rom[ROM_AW-1:0];
            exp_res.ram_enabled = ram_on();
            expected_q.push_back(exp_res);
        endfunction

        function void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
            errors++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
        endfunction

        // Compare one result with the oldest pending expectation
        function void check(cbm_result_t got);
            cbm_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item pending: expected none, got %h",
                    $time, got);
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.rom_addr !== exp_res.rom_addr)
                report("rom_addr", 32'(exp_res.rom_addr), 32'(got.rom_addr));
            if (got.ram_data !== exp_res.ram_data)
                report("ram_data", 32'(exp_res.ram_data), 32'(got.ram_data));
            if (got.ram_enabled !== exp_res.ram_enabled)
                report("ram_enabled", 32'(exp_res.ram_enabled), 32'(got.ram_enabled));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cbm_req_t    req;
    logic        done;
    cbm_result_t result;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;

    map_scoreboard sb;
    int idle_pct;
    int cycles;

    cartridge_bank_mapper_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Check every strobed result
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done !== 1'b0)
            sb.check(result);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic cbm_req_t bus_req(logic [2:0] t, logic [15:0] a, logic [7:0] d);
        cbm_req_t r;
        r.req_type = t;
        r.addr = a;
        r.data = d;
        return r;
    endfunction

    // Build one random access, mostly well-formed traffic with RAM enabled
    function automatic cbm_req_t random_item();
        cbm_req_t r;
        int pick;
        int region;
        logic [15:0] a;
        r.req_type = REQ_ROM_LO;
        r.addr = 16'($urandom);
        r.data = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 20)
            r.req_type = REQ_ROM_LO;
        else if (pick < 40)
            r.req_type = REQ_ROM_HI;
        else if (pick < 55)
        begin
            r.req_type = REQ_RAM_RD;
            // never read a byte that has not been written
            if (sb.ram_on())
            begin
                if (sb.find_read_addr(a))
                    r.addr = a;
                else
                    r.req_type = REQ_RAM_WR;
            end
        end
        else if (pick < 75)
        begin
            r.req_type = REQ_RAM_WR;
            if ($urandom_range(1))
                r.addr[RAM_PAGE_BITS-1:0] = 13'($urandom_range(15));
        end
        else if (pick < 95)
        begin
            r.req_type = REQ_REG_WR;
            region = $urandom_range(9);
            if (region < 4)
            begin
                r.addr[15:13] = REGION_LOCK_ENABLE;
                if ($urandom_range(3) != 0)
                    r.data[3:0] = RAM_ON_CODE;
            end
            else if (region < 6)
                r.addr[15:13] = REGION_ROM_BANK;
            else if (region < 8)
                r.addr[15:13] = REGION_RAM_BANK;
            else
                r.addr[15:13] = 3'($urandom_range(3, 7));
        end
        else
            r.req_type = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
        return r;
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input cbm_req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        forever
        begin
            @(posedge clk);
            if (busy === 1'b0)
                break;
        end
        sb.note_item(r);
    endtask

    // Hold off until every pending result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rom_size(input logic [4:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.rom_log2 = v;
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [4:0] phase_cfg [6];
        int         phase_idle [6];
        sb = new();
        idle_pct = 7;
        cycles <= 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unlocked: last 32K mapping, base writes, ignored writes, RAM off
        send_item(bus_req(REQ_ROM_LO, 16'h0000, 8'h00));
        send_item(bus_req(REQ_ROM_HI, 16'hFFFF, 8'hFF));
        send_item(bus_req(REQ_REG_WR, 16'h2000, 8'h00));
        send_item(bus_req(REQ_REG_WR, 16'h3FFF, 8'hFF));
        send_item(bus_req(REQ_REG_WR, 16'h4000, 8'h03));
        send_item(bus_req(REQ_REG_WR, 16'h6000, 8'hFF));
        send_item(bus_req(REQ_REG_WR, 16'hFFFF, 8'h00));
        send_item(bus_req(REQ_RAM_RD, 16'hA000, 8'h00));
        send_item(bus_req(REQ_RAM_WR, 16'hBFFF, 8'h55));
        send_item(bus_req(3'd5, 16'hFFFF, 8'hFF));
        send_item(bus_req(3'd6, 16'h0000, 8'h00));
        send_item(bus_req(REQ_BAD_HI, 16'h5555, 8'hAA));

        // Size register above and below its legal range
        write_rom_size(5'd31);
        send_item(bus_req(REQ_ROM_LO, 16'h7FFF, 8'h00));
        send_item(bus_req(REQ_ROM_HI, 16'h4000, 8'h00));
        write_rom_size(5'd0);
        send_item(bus_req(REQ_ROM_HI, 16'hC000, 8'h00));
        write_rom_size(ROM_LOG2_MAX);
        send_item(bus_req(REQ_REG_WR, 16'h2000 | 16'($urandom_range(16'h1FFF)),
            8'($urandom)));

        // Lock (data ignored), then enable RAM and drive the banks to extremes
        send_item(bus_req(REQ_REG_WR, 16'h1FFF, 8'hAA));
        send_item(bus_req(REQ_RAM_RD, 16'h0000, 8'h00));
        send_item(bus_req(REQ_REG_WR, 16'h0000, 8'h0A));
        send_item(bus_req(REQ_REG_WR, 16'h2000, 8'hFF));
        send_item(bus_req(REQ_REG_WR, 16'h5FFF, 8'hFF));
        send_item(bus_req(REQ_RAM_WR, 16'hBFFF, 8'hA5));
        send_item(bus_req(REQ_RAM_RD, 16'hBFFF, 8'h00));
        send_item(bus_req(REQ_ROM_LO, 16'hFFFF, 8'h00));
        send_item(bus_req(REQ_ROM_HI, 16'hFFFF, 8'h00));
        send_item(bus_req(REQ_REG_WR, 16'h1000, 8'h0B));
        send_item(bus_req(REQ_RAM_RD, 16'hBFFF, 8'h00));
        send_item(bus_req(REQ_REG_WR, 16'h0000, 8'hFA));

        // Random phases: sparse gaps, heavy gaps, then back to back
        phase_cfg[0] = ROM_LOG2_MAX;
        phase_cfg[1] = ROM_LOG2_MIN;
        phase_cfg[2] = 5'd31;
        phase_cfg[3] = 5'd0;
        phase_cfg[4] = 5'($urandom_range(16, 22));
        phase_cfg[5] = 5'($urandom_range(31));
        phase_idle[0] = 7;
        phase_idle[1] = 7;
        phase_idle[2] = 65;
        phase_idle[3] = 65;
        phase_idle[4] = 0;
        phase_idle[5] = 0;
        for (int p = 0; p < 6; p++)
        begin
            idle_pct = phase_idle[p];
            write_rom_size(phase_cfg[p]);
            repeat (PHASE_ITEMS) send_item(random_item());
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
